// ===== hw/rtl/bmh_pkg.sv =====
// shared types, sizes and codes for the binary min-heap
package bmh_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = IDX_W + 1;
  localparam int KEY_W    = 32;
  localparam int ACT_W    = 2;
  localparam int POS_W    = 7;
  localparam int ST_W     = 2;
  localparam int CNT_OUT_W = 8;

  typedef logic [ACT_W-1:0]        act_t;
  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [ST_W-1:0]         status_t;
  typedef logic [CNT_OUT_W-1:0]    cnt_out_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CHILD_W-1:0]      child_t;

  localparam act_t ACT_INSERT  = 2'd0;
  localparam act_t ACT_EXTRACT = 2'd1;
  localparam act_t ACT_DELETE  = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  localparam key_t KEY_EMPTY = -32'sd1;
  localparam cnt_t CNT_FULL  = CNT_W'(CAPACITY);

  typedef struct packed {
    act_t action;
    key_t item_value;
    pos_t position;
  } bmh_req_t;

  typedef struct packed {
    key_t     min_value;
    status_t  status;
    cnt_out_t entry_count;
  } bmh_res_t;

  typedef struct packed {
    logic we;
    idx_t waddr;
    key_t wdata;
    logic re;
    idx_t raddr;
  } bmh_ram_req_t;

endpackage

// ===== hw/rtl/bmh_if.sv =====
// request and response channel interfaces of the binary min-heap
interface bmh_req_if;
  import bmh_pkg::*;
  logic valid;
  logic ready;
  act_t action;
  key_t item_value;
  pos_t position;
  modport source (output valid, output action, output item_value, output position,
                  input ready);
  modport sink (input valid, input action, input item_value, input position,
                output ready);
endinterface

interface bmh_rsp_if;
  import bmh_pkg::*;
  logic     valid;
  logic     ready;
  key_t     min_value;
  status_t  status;
  cnt_out_t entry_count;
  modport source (output valid, output min_value, output status, output entry_count,
                  input ready);
  modport sink (input valid, input min_value, input status, input entry_count,
                output ready);
endinterface

// ===== hw/rtl/binary_min_heap.sv =====
// binary min-heap top level: key ram, sequencer and output register
// a refused or trivial request needs no heap walk; others sift up by reading each parent
//   and sift down by reading the children of the hole, one level after another
// requests are handled one at a time; the single ram read port paces the walk
// the next request is taken while the previous result waits in the output register
// reset: asynchronous active low, empties the heap; key ram contents are not cleared
module binary_min_heap (
  input logic      clk_i,
  input logic      rst_ni,
  bmh_req_if.sink   req_i,
  bmh_rsp_if.source rsp_o
);
  import bmh_pkg::*;

  bmh_req_t     req;
  bmh_res_t     res;
  bmh_res_t     out_q;
  bmh_ram_req_t ram_req;
  key_t         rdata;
  logic [KEY_W-1:0] rdata_raw;
  logic         done;
  logic         slot_free;
  logic         out_valid_q;

  assign req.action     = req_i.action;
  assign req.item_value = req_i.item_value;
  assign req.position   = req_i.position;

  bmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req),
    .slot_free_i (slot_free),
    .done_o      (done),
    .res_o       (res),
    .ram_o       (ram_req),
    .rdata_i     (rdata)
  );

  bmh_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = key_t'(rdata_raw);

  // output slot frees up in the same cycle its beat is taken
  assign slot_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.min_value   = out_q.min_value;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.entry_count = out_q.entry_count;

endmodule

// ===== hw/rtl/bmh_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
module bmh_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bmh_ctrl.sv =====
// heap sequencer: count register and sift-up / sift-down walk over the key ram
module bmh_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  bmh_pkg::bmh_req_t     req_i,
  input  logic                  slot_free_i,
  output logic                  done_o,
  output bmh_pkg::bmh_res_t     res_o,
  output bmh_pkg::bmh_ram_req_t ram_o,
  input  bmh_pkg::key_t         rdata_i
);
  import bmh_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EX_ROOT = 4'd1;
  localparam logic [3:0] S_LD_LAST = 4'd2;
  localparam logic [3:0] S_DL_PAR  = 4'd3;
  localparam logic [3:0] S_SU_RD   = 4'd4;
  localparam logic [3:0] S_SU_CMP  = 4'd5;
  localparam logic [3:0] S_SD_RD   = 4'd6;
  localparam logic [3:0] S_SD_L    = 4'd7;
  localparam logic [3:0] S_SD_R    = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0] state_q, state_d;
  cnt_t       cnt_q, cnt_d;
  idx_t       hole_q, hole_d;
  child_t     child_q, child_d;
  key_t       key_q, key_d;
  key_t       left_q, left_d;
  key_t       minv_q, minv_d;
  status_t    status_q, status_d;

  logic   accept;
  idx_t   parent;
  child_t first_child;
  child_t second_child;
  child_t cnt_x;
  key_t   cand;
  child_t cand_idx;

  assign req_ready_o  = (state_q == S_IDLE);
  assign accept       = req_valid_i && req_ready_o;
  assign parent       = idx_t'((hole_q - 1'b1) >> 1);
  assign first_child  = {hole_q, 1'b1};
  assign second_child = child_t'(child_q + 1'b1);
  assign cnt_x        = child_t'(cnt_q);

  // smaller child, left one on a tie
  always_comb begin
    if (left_q > rdata_i) begin
      cand     = rdata_i;
      cand_idx = second_child;
    end else begin
      cand     = left_q;
      cand_idx = child_q;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    hole_d   = hole_q;
    child_d  = child_q;
    key_d    = key_q;
    left_d   = left_q;
    minv_d   = minv_q;
    status_d = status_q;
    ram_o    = '0;
    done_o   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          minv_d   = '0;
          status_d = ST_OK;
          case (req_i.action)
            ACT_INSERT: begin
              if (cnt_q == CNT_FULL) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                key_d   = req_i.item_value;
                hole_d  = idx_t'(cnt_q);
                cnt_d   = cnt_q + 1'b1;
                state_d = S_SU_RD;
              end
            end
            ACT_EXTRACT: begin
              if (cnt_q == '0) begin
                minv_d   = KEY_EMPTY;
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                ram_o.re    = 1'b1;
                ram_o.raddr = '0;
                hole_d      = '0;
                state_d     = S_EX_ROOT;
              end
            end
            ACT_DELETE: begin
              if (32'(req_i.position) >= 32'(cnt_q)) begin
                status_d = ST_RANGE;
                state_d  = S_DONE;
              end else begin
                cnt_d  = cnt_q - 1'b1;
                hole_d = idx_t'(req_i.position);
                if (32'(req_i.position) == 32'(cnt_q - 1'b1)) begin
                  // removing the last entry only shrinks the heap
                  state_d = S_DONE;
                end else begin
                  ram_o.re    = 1'b1;
                  ram_o.raddr = idx_t'(cnt_q - 1'b1);
                  state_d     = S_LD_LAST;
                end
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_EX_ROOT: begin
        minv_d = rdata_i;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == cnt_t'(1)) begin
          state_d = S_DONE;
        end else begin
          ram_o.re    = 1'b1;
          ram_o.raddr = idx_t'(cnt_q - 1'b1);
          state_d     = S_LD_LAST;
        end
      end

      S_LD_LAST: begin
        key_d = rdata_i;
        if (hole_q != '0) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = parent;
          state_d     = S_DL_PAR;
        end else begin
          state_d = S_SD_RD;
        end
      end

      // moved entry may be smaller than its parent after a delete
      S_DL_PAR: begin
        if (rdata_i > key_q) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = hole_q;
          ram_o.wdata = rdata_i;
          hole_d      = parent;
          state_d     = S_SU_RD;
        end else begin
          state_d = S_SD_RD;
        end
      end

      S_SU_RD: begin
        if (hole_q == '0) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = hole_q;
          ram_o.wdata = key_q;
          state_d     = S_DONE;
        end else begin
          ram_o.re    = 1'b1;
          ram_o.raddr = parent;
          state_d     = S_SU_CMP;
        end
      end

      S_SU_CMP: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = hole_q;
        if (rdata_i > key_q) begin
          ram_o.wdata = rdata_i;
          hole_d      = parent;
          state_d     = S_SU_RD;
        end else begin
          ram_o.wdata = key_q;
          state_d     = S_DONE;
        end
      end

      S_SD_RD: begin
        if (first_child >= cnt_x) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = hole_q;
          ram_o.wdata = key_q;
          state_d     = S_DONE;
        end else begin
          ram_o.re    = 1'b1;
          ram_o.raddr = idx_t'(first_child);
          child_d     = first_child;
          state_d     = S_SD_L;
        end
      end

      S_SD_L: begin
        left_d = rdata_i;
        if (second_child < cnt_x) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = idx_t'(second_child);
          state_d     = S_SD_R;
        end else begin
          ram_o.we    = 1'b1;
          ram_o.waddr = hole_q;
          if (rdata_i < key_q) begin
            ram_o.wdata = rdata_i;
            hole_d      = idx_t'(child_q);
            state_d     = S_SD_RD;
          end else begin
            ram_o.wdata = key_q;
            state_d     = S_DONE;
          end
        end
      end

      S_SD_R: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = hole_q;
        if (cand < key_q) begin
          ram_o.wdata = cand;
          hole_d      = idx_t'(cand_idx);
          state_d     = S_SD_RD;
        end else begin
          ram_o.wdata = key_q;
          state_d     = S_DONE;
        end
      end

      S_DONE: begin
        if (slot_free_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.min_value   = minv_q;
  assign res_o.status      = status_q;
  assign res_o.entry_count = cnt_out_t'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q   <= hole_d;
    child_q  <= child_d;
    key_q    <= key_d;
    left_q   <= left_d;
    minv_q   <= minv_d;
    status_q <= status_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("heap count above capacity");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_o.we && ram_o.re) |-> (ram_o.waddr != ram_o.raddr))
    else $error("read and write to the same entry in one cycle");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_o.we |-> (child_t'(ram_o.waddr) < cnt_x))
    else $error("write beyond the live part of the heap");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.action == ACT_INSERT && cnt_q == CNT_FULL)
    |=> (state_q == S_DONE && status_q == ST_FULL && $stable(cnt_q)))
    else $error("insert into a full heap not refused");

endmodule
